// ===== sv/rlf_pkg.sv =====
// Shared constants, coefficient table and control types for the respiration low-pass FIR.
package rlf_pkg;

	localparam int TAPS         = 161;
	localparam int SAMPLE_WIDTH = 20;
	localparam int OUT_W        = 16;
	localparam int OUT_SHIFT    = 15;
	localparam int SAT_W        = 31;

	localparam int HIST_DEPTH = TAPS - 1;
	localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int TAP_W      = $clog2(TAPS);
	localparam int PTR_W      = TAP_W + 1;

	localparam int COEF_COUNT = 161;
	localparam int COEF_W     = 12;
	localparam int COEF_IDX_W = 8;

	localparam int PROD_W    = COEF_W + SAMPLE_WIDTH;
	localparam int ACC_RAW_W = PROD_W + TAP_W;
	localparam int ACC_W     = (ACC_RAW_W > SAT_W + 1) ? ACC_RAW_W : SAT_W + 1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sh0000_0000_3fff_ffff);
	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-64'sh0000_0000_4000_0000);

	localparam logic signed [COEF_W-1:0] LP_COEF [COEF_COUNT] = '{
		 12'sd120,  12'sd124,  12'sd126,  12'sd127,  12'sd127,  12'sd125,  12'sd122,
		 12'sd118,  12'sd113,  12'sd106,   12'sd97,   12'sd88,   12'sd77,   12'sd65,
		  12'sd52,   12'sd38,   12'sd24,    12'sd8,   -12'sd8,  -12'sd25,  -12'sd42,
		 -12'sd59,  -12'sd76,  -12'sd93, -12'sd110, -12'sd126, -12'sd142, -12'sd156,
		-12'sd170, -12'sd183, -12'sd194, -12'sd203, -12'sd211, -12'sd217, -12'sd221,
		-12'sd223, -12'sd223, -12'sd220, -12'sd215, -12'sd208, -12'sd198, -12'sd185,
		-12'sd170, -12'sd152, -12'sd132, -12'sd108,  -12'sd83,  -12'sd55,  -12'sd24,
		   12'sd8,   12'sd43,   12'sd80,  12'sd119,  12'sd159,  12'sd201,  12'sd244,
		 12'sd288,  12'sd333,  12'sd378,  12'sd424,  12'sd470,  12'sd516,  12'sd561,
		 12'sd606,  12'sd650,  12'sd693,  12'sd734,  12'sd773,  12'sd811,  12'sd847,
		 12'sd880,  12'sd911,  12'sd939,  12'sd964,  12'sd986, 12'sd1005, 12'sd1020,
		12'sd1033, 12'sd1041, 12'sd1047, 12'sd1049, 12'sd1047, 12'sd1041, 12'sd1033,
		12'sd1020, 12'sd1005,  12'sd986,  12'sd964,  12'sd939,  12'sd911,  12'sd880,
		 12'sd847,  12'sd811,  12'sd773,  12'sd734,  12'sd693,  12'sd650,  12'sd606,
		 12'sd561,  12'sd516,  12'sd470,  12'sd424,  12'sd378,  12'sd333,  12'sd288,
		 12'sd244,  12'sd201,  12'sd159,  12'sd119,   12'sd80,   12'sd43,    12'sd8,
		 -12'sd24,  -12'sd55,  -12'sd83, -12'sd108, -12'sd132, -12'sd152, -12'sd170,
		-12'sd185, -12'sd198, -12'sd208, -12'sd215, -12'sd220, -12'sd223, -12'sd223,
		-12'sd221, -12'sd217, -12'sd211, -12'sd203, -12'sd194, -12'sd183, -12'sd170,
		-12'sd156, -12'sd142, -12'sd126, -12'sd110,  -12'sd93,  -12'sd76,  -12'sd59,
		 -12'sd42,  -12'sd25,   -12'sd8,    12'sd8,   12'sd24,   12'sd38,   12'sd52,
		  12'sd65,   12'sd77,   12'sd88,   12'sd97,  12'sd106,  12'sd113,  12'sd118,
		 12'sd122,  12'sd125,  12'sd127,  12'sd127,  12'sd126,  12'sd124,  12'sd120
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_FLUSH,
		ST_OUT
	} rlf_state_t;

	// One tap travelling alongside the history read.
	typedef struct packed {
		logic                     act;
		logic                     tap0;
		logic signed [COEF_W-1:0] coef;
	} rlf_tap_t;

	// Taps past the end of the table carry a zero weight.
	function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_W-1:0] k);
		logic [COEF_IDX_W-1:0] idx;
		idx = COEF_IDX_W'(k);
		if (int'(k) < COEF_COUNT)
			return LP_COEF[idx];
		return '0;
	endfunction

endpackage

// ===== sv/rlf_hist_mem.sv =====
// Sample history memory: one write port, one registered read port, per-entry valid bits.
module rlf_hist_mem
	import rlf_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ADDR_W-1:0]              wr_addr,
	input  logic signed [SAMPLE_WIDTH-1:0] wr_data,
	input  logic [ADDR_W-1:0]              rd_addr,
	output logic signed [SAMPLE_WIDTH-1:0] rd_data_s1,
	output logic                           rd_vld_s1
);

	logic signed [SAMPLE_WIDTH-1:0] mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0]          vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[rd_addr];
	end

	// Entries never written read as zero through their valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

endmodule

// ===== sv/rlf_mac.sv =====
// Shared multiply-accumulate with saturation and output scaling.
module rlf_mac
	import rlf_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  rlf_tap_t                       tap_s1,
	input  logic signed [SAMPLE_WIDTH-1:0] rd_data_s1,
	input  logic                           rd_vld_s1,
	input  logic signed [SAMPLE_WIDTH-1:0] cur_sample,
	output logic signed [OUT_W-1:0]        result
);

	logic signed [SAMPLE_WIDTH-1:0] operand;
	logic signed [PROD_W-1:0]       prod_s2;
	logic                           act_s2;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [ACC_W-1:0]        clamp;

	always_comb begin
		if (tap_s1.tap0)
			operand = cur_sample;
		else if (rd_vld_s1)
			operand = rd_data_s1;
		else
			operand = '0;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(tap_s1.coef * operand);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			act_s2 <= tap_s1.act;
			if (clear)
				acc_q <= '0;
			else if (act_s2)
				acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_comb begin
		priority if (acc_q > ACC_MAX)
			clamp = ACC_MAX;
		else if (acc_q < ACC_MIN)
			clamp = ACC_MIN;
		else
			clamp = acc_q;
	end

	// Arithmetic shift of the clamped sum floors toward minus infinity.
	assign result = clamp[SAT_W-1:OUT_SHIFT];

endmodule

// ===== sv/respiration_lowpass_fir_core.sv =====
// An accepted request goes through ST_ISSUE over all taps, then ST_FLUSH and ST_OUT (store).
// The single shared multiplier takes one tap a cycle; requests are taken only in ST_IDLE.
// The history memory is read once per tap and written once per request at the end.
// A finished result waits in the output register; the next request runs meanwhile.
// Reset clears the history valid bits, write pointer, accumulator and control state.
module respiration_lowpass_fir_core
	import rlf_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [OUT_W-1:0]        filtered
);

	rlf_state_t                     state_q, state_d;
	logic [TAP_W-1:0]               tap_q;
	logic [ADDR_W-1:0]              wp_q;
	logic                           flush_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic                           out_valid_q;
	logic signed [OUT_W-1:0]        filtered_q;

	logic                           accept;
	logic                           issue;
	logic                           finish;
	logic [PTR_W-1:0]               rd_sum;
	logic [ADDR_W-1:0]              rd_addr;
	rlf_tap_t                       tap_s1;
	logic signed [SAMPLE_WIDTH-1:0] rd_data_s1;
	logic                           rd_vld_s1;
	logic signed [OUT_W-1:0]        mac_result;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				issue = 1'b1;
				if (tap_q == TAP_W'(TAPS - 1))
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (flush_q)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = in_valid && in_ready;

	// Tap k reads the sample k steps back from the write slot.
	always_comb begin
		rd_sum = PTR_W'(wp_q) + PTR_W'(HIST_DEPTH) - PTR_W'(tap_q);
		if (rd_sum >= PTR_W'(HIST_DEPTH))
			rd_sum = rd_sum - PTR_W'(HIST_DEPTH);
		rd_addr = rd_sum[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			wp_q        <= '0;
			flush_q     <= 1'b0;
			tap_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				tap_q <= '0;
			else if (issue)
				tap_q <= tap_q + 1'b1;
			if (state_q == ST_FLUSH)
				flush_q <= !flush_q;
			else
				flush_q <= 1'b0;
			tap_s1.act  <= issue;
			tap_s1.tap0 <= (tap_q == '0);
			tap_s1.coef <= coef_at(tap_q);
			if (finish)
				wp_q <= (wp_q == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			x_q <= sample;
		if (finish)
			filtered_q <= mac_result;
	end

	rlf_hist_mem u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (finish),
		.wr_addr    (wp_q),
		.wr_data    (x_q),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rd_data_s1),
		.rd_vld_s1  (rd_vld_s1)
	);

	rlf_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept),
		.tap_s1     (tap_s1),
		.rd_data_s1 (rd_data_s1),
		.rd_vld_s1  (rd_vld_s1),
		.cur_sample (x_q),
		.result     (mac_result)
	);

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

endmodule
